// ----- design/pbf_pkg.sv -----
// Package for the piece bitfield engine: sizes, request codes, FSM states
// and the byte popcount helper. No dependencies.
package pbf_pkg;

   localparam int MAX_PIECES  = 4096;
   localparam int STORE_BYTES = (MAX_PIECES + 7) / 8;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int LEN_W       = $clog2(STORE_BYTES + 1);
   localparam int COUNT_W     = 13;
   localparam int PIDX_W      = 12;
   localparam int BIDX_W      = 9;

   typedef enum logic [2:0] {
      REQ_READ  = 3'd0,
      REQ_WRITE = 3'd1,
      REQ_CLEAR = 3'd2,
      REQ_SET   = 3'd3,
      REQ_LOAD  = 3'd4,
      REQ_PEER  = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_COUNT
   } state_type;

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

endpackage

// ----- design/pbf_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- design/piece_bitfield_engine.sv -----
// Piece bitfield engine: bit/byte requests are read, then modified/written;
// the result strobe is registered after the modify/write step, while the next request can already start.
// Clear/set all writes len = ceil(valid_pieces/8) bytes, with valid_pieces clamped to MAX_PIECES.
// A valid_pieces write recounts held pieces, busy while each of the len bytes is read.
// After reset, busy while the byte store is swept to zero.
// Results cannot be stalled. Uses pbf_pkg and pbf_ram.
module piece_bitfield_engine
   import pbf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic [PIDX_W-1:0]  req_piece_index,
   input  logic               req_bit_value,
   input  logic [BIDX_W-1:0]  req_byte_index,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   // response channel
   output logic               rsp_strobe,
   output logic               rsp_read_bit,
   output logic               rsp_status,
   output logic               rsp_interested,
   output logic               rsp_interest_valid,
   output logic [COUNT_W-1:0] rsp_piece_count,
   // configuration
   input  logic               csr_write_en,
   input  logic [COUNT_W-1:0] csr_valid_pieces
);

   // ------------------------------------------------------------------
   // Configuration: clamp piece count and derive byte length and the
   // mask of valid bits in the last byte (full byte when count % 8 == 0).
   // ------------------------------------------------------------------
   logic [COUNT_W-1:0] eff_ff, eff_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [ADDR_W-1:0]  last_addr_ff, last_addr_in;
   logic [7:0]         last_mask_ff, last_mask_in;
   logic [COUNT_W-1:0] eff_plus7;

   always_comb begin
      eff_in = (csr_valid_pieces > COUNT_W'(MAX_PIECES)) ? COUNT_W'(MAX_PIECES)
                                                          : csr_valid_pieces;
      eff_plus7    = eff_in + COUNT_W'(7);
      len_in       = LEN_W'(eff_plus7 >> 3);
      last_addr_in = ADDR_W'(len_in - LEN_W'(1));
      last_mask_in = (eff_in[2:0] == 3'd0) ? 8'hff : ~(8'hff >> eff_in[2:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff       <= '0;
         len_ff       <= '0;
         last_addr_ff <= '0;
         last_mask_ff <= 8'hff;
      end else if (csr_write_en) begin
         eff_ff       <= eff_in;
         len_ff       <= len_in;
         last_addr_ff <= last_addr_in;
         last_mask_ff <= last_mask_in;
      end
   end

   // ------------------------------------------------------------------
   // Byte store
   // ------------------------------------------------------------------
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   pbf_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------
   // Request latch. Range check is done at accept time.
   // ------------------------------------------------------------------
   state_type    state_ff, state_in;
   req_code_type op_type_ff;
   logic [2:0]   op_bit_ff;
   logic [ADDR_W-1:0] op_addr_ff;
   logic         op_bval_ff;
   logic [7:0]   op_data_ff;
   logic         op_last_ff;
   logic         op_err_ff;

   logic         accept;
   req_code_type in_code;
   logic         in_bitop;
   logic         in_err;
   logic [ADDR_W-1:0] in_addr;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      in_code  = req_code_type'(req_type);
      in_bitop = (in_code == REQ_READ) || (in_code == REQ_WRITE);
      in_addr  = in_bitop ? ADDR_W'(req_piece_index >> 3) : ADDR_W'(req_byte_index);
      unique case (in_code)
         REQ_READ, REQ_WRITE:
            in_err = ({1'b0, req_piece_index} >= eff_ff);
         REQ_LOAD, REQ_PEER:
            in_err = ({1'b0, req_byte_index} >= len_ff);
         REQ_CLEAR, REQ_SET:
            in_err = 1'b0;
         default:
            in_err = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_type_ff <= in_code;
         op_bit_ff  <= req_piece_index[2:0];
         op_addr_ff <= in_addr;
         op_bval_ff <= req_bit_value;
         op_data_ff <= req_data_byte;
         op_last_ff <= req_last_byte;
         op_err_ff  <= in_err;
      end
   end

   // ------------------------------------------------------------------
   // Main FSM: read in IDLE (accept cycle), modify/write in EXEC,
   // sweeps for clear/set, recount and power-up clear.
   // ------------------------------------------------------------------
   logic [LEN_W-1:0]   ctr_ff, ctr_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [COUNT_W-1:0] held_ff, held_in;
   logic               intr_ff, intr_in;

   logic               rsp_valid_in;
   logic               rsp_rbit_in, rsp_status_in, rsp_intr_in, rsp_ivalid_in;

   logic [7:0] op_mask, bit_mask, cnt_mask, peer_hits;
   logic       old_bit, flag_next;

   always_comb begin
      op_mask   = (op_addr_ff == last_addr_ff) ? last_mask_ff : 8'hff;
      cnt_mask  = (pend_addr_ff == last_addr_ff) ? last_mask_ff : 8'hff;
      bit_mask  = 8'h80 >> op_bit_ff;
      old_bit   = |(ram_rdata & bit_mask);
      peer_hits = ram_rdata & ~op_data_ff & op_mask;
      flag_next = intr_ff | (!op_err_ff && (|peer_hits));
   end

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      held_in      = held_ff;
      intr_in      = intr_ff;

      ram_we    = 1'b0;
      ram_waddr = op_addr_ff;
      ram_wdata = op_data_ff;
      ram_raddr = in_addr;

      rsp_valid_in  = 1'b0;
      rsp_rbit_in   = 1'b0;
      rsp_status_in = op_err_ff;
      rsp_intr_in   = 1'b0;
      rsp_ivalid_in = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            // zero the whole store once after reset
            ram_we    = 1'b1;
            ram_waddr = ctr_ff[ADDR_W-1:0];
            ram_wdata = 8'h00;
            ctr_in    = ctr_ff + LEN_W'(1);
            if (ctr_ff[ADDR_W-1:0] == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
               ctr_in   = '0;
            end
         end

         ST_IDLE: begin
            if (csr_write_en) begin
               state_in = ST_COUNT;
               ctr_in   = '0;
               held_in  = '0;
            end else if (start) begin
               ctr_in = '0;
               if (in_code == REQ_CLEAR || in_code == REQ_SET) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (op_type_ff)
               REQ_READ: begin
                  rsp_rbit_in = !op_err_ff && old_bit;
               end
               REQ_WRITE: begin
                  if (!op_err_ff) begin
                     ram_we    = 1'b1;
                     ram_wdata = op_bval_ff ? (ram_rdata | bit_mask)
                                            : (ram_rdata & ~bit_mask);
                     if (old_bit != op_bval_ff) begin
                        held_in = op_bval_ff ? held_ff + COUNT_W'(1)
                                             : held_ff - COUNT_W'(1);
                     end
                  end
               end
               REQ_LOAD: begin
                  if (!op_err_ff) begin
                     ram_we    = 1'b1;
                     ram_wdata = op_data_ff;
                     held_in   = held_ff
                               - COUNT_W'(pop8(ram_rdata & op_mask))
                               + COUNT_W'(pop8(op_data_ff & op_mask));
                  end
               end
               REQ_PEER: begin
                  // answer on the last beat, then restart the stream
                  if (op_last_ff) begin
                     rsp_intr_in   = flag_next;
                     rsp_ivalid_in = 1'b1;
                     intr_in       = 1'b0;
                  end else begin
                     intr_in = flag_next;
                  end
               end
               default: begin
                  // unknown request: status only (flagged at accept)
               end
            endcase
         end

         ST_SWEEP: begin
            ram_waddr = ctr_ff[ADDR_W-1:0];
            ram_wdata = (op_type_ff == REQ_SET) ? 8'hff : 8'h00;
            ram_we    = (ctr_ff < len_ff);
            ctr_in    = ctr_ff + LEN_W'(1);
            if ((ctr_ff + LEN_W'(1)) >= len_ff) begin
               state_in     = ST_IDLE;
               held_in      = (op_type_ff == REQ_SET) ? eff_ff : '0;
               rsp_valid_in = 1'b1;
            end
         end

         ST_COUNT: begin
            // read byte ctr, accumulate its masked popcount once the registered read returns
            ram_raddr = ctr_ff[ADDR_W-1:0];
            if (ctr_ff < len_ff) begin
               ctr_in       = ctr_ff + LEN_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = ctr_ff[ADDR_W-1:0];
            end
            if (pend_ff) begin
               held_in = held_ff + COUNT_W'(pop8(ram_rdata & cnt_mask));
            end
            if (ctr_ff >= len_ff && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ctr_ff       <= '0;
         pend_ff      <= 1'b0;
         pend_addr_ff <= '0;
         held_ff      <= '0;
         intr_ff      <= 1'b0;
         rsp_strobe   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         pend_ff      <= pend_in;
         pend_addr_ff <= pend_addr_in;
         held_ff      <= held_in;
         intr_ff      <= intr_in;
         rsp_strobe   <= rsp_valid_in;
      end
   end

   // response beat, shown for one cycle
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_read_bit       <= rsp_rbit_in;
         rsp_status         <= rsp_status_in;
         rsp_interested     <= rsp_intr_in;
         rsp_interest_valid <= rsp_ivalid_in;
         rsp_piece_count    <= held_in;
      end
   end

endmodule
